### design/cvd_pkg.sv
package cvd_pkg;

    localparam int unsigned BASE_YEAR    = 1970;
    localparam int unsigned MONTHS       = 12;
    localparam int unsigned YEAR_TAB_LEN = 256;

    // x / 60 == (x * RECIP_60) >> SHIFT_60 for every 32-bit x
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam int unsigned SHIFT_60 = 37;
    // x / 3 == (x * RECIP_3) >> SHIFT_3 for every 32-bit x
    localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;
    localparam int unsigned SHIFT_3  = 33;
    // Year estimate: days * 2^24 / 365.25, off by at most one year
    localparam logic [15:0] RECIP_YEAR = 16'd45934;
    localparam int unsigned SHIFT_YEAR = 24;

    typedef logic [15:0] t_day_count;
    typedef logic [8:0]  t_day_of_year;
    typedef logic [7:0]  t_year_idx;
    typedef logic [3:0]  t_month_idx;

    localparam t_month_idx MONTH_MAR = 4'd2;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_hms;

    typedef struct packed {
        t_day_count days;
        t_hms       hms;
    } t_split;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        t_hms        hms;
    } t_civil;

    typedef t_day_count   t_year_tab  [YEAR_TAB_LEN];
    typedef t_day_of_year t_month_tab [MONTHS];

    localparam int unsigned MONTH_LEN [MONTHS] = '{
        31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };

    function automatic bit is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Day number of January 1st of each year, counted from the base year
    function automatic t_year_tab build_year_start();
        t_year_tab   tab;
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i < YEAR_TAB_LEN; i++) begin
            tab[i] = t_day_count'(acc);
            acc    = acc + (is_leap(BASE_YEAR + i) ? 366 : 365);
        end
        return tab;
    endfunction

    function automatic logic [YEAR_TAB_LEN-1:0] build_leap_tab();
        logic [YEAR_TAB_LEN-1:0] tab;
        for (int unsigned i = 0; i < YEAR_TAB_LEN; i++) begin
            tab[i] = is_leap(BASE_YEAR + i);
        end
        return tab;
    endfunction

    // Day of year on which each month starts in a common year
    function automatic t_month_tab build_month_start();
        t_month_tab  tab;
        int unsigned acc;
        acc = 0;
        for (int unsigned m = 0; m < MONTHS; m++) begin
            tab[m] = t_day_of_year'(acc);
            acc    = acc + MONTH_LEN[m];
        end
        return tab;
    endfunction

    localparam t_year_tab               YEAR_START  = build_year_start();
    localparam logic [YEAR_TAB_LEN-1:0] LEAP_TAB    = build_leap_tab();
    localparam t_month_tab              MONTH_START = build_month_start();

    function automatic t_day_of_year month_start(t_month_idx m, logic leap);
        t_day_of_year base;
        base = MONTH_START[m];
        if (leap && m >= MONTH_MAR) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

### design/cvd_ifs.sv
interface cvd_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface cvd_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;

    modport source (output valid, output year_out, output month_out, output day_out,
                    output hour_out, output minute_out, output second_out, input ready);
    modport sink   (input valid, input year_out, input month_out, input day_out,
                    input hour_out, input minute_out, input second_out, output ready);
endinterface

### design/cvd_time_split.sv
module cvd_time_split (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [31:0]      i_epoch,
    output logic             o_valid,
    input  logic             i_ready,
    output cvd_pkg::t_split  o_split
);
    import cvd_pkg::*;

    localparam int unsigned STAGES = 6;

    logic [STAGES:1] r_vld;
    logic [STAGES:1] vld_in;
    logic [STAGES:1] stage_en;

    // Stage 1: seconds times reciprocal of 60
    logic [31:0] r_t1;
    logic [63:0] r_p1;
    // Stage 2: total minutes, second
    logic [26:0] r_q1_2;
    logic [5:0]  r_sec2;
    // Stage 3: minutes times reciprocal of 60
    logic [26:0] r_q1_3;
    logic [63:0] r_p2;
    logic [5:0]  r_sec3;
    // Stage 4: total hours, minute
    logic [20:0] r_q2_4;
    logic [5:0]  r_min4;
    logic [5:0]  r_sec4;
    // Stage 5: hours / 8 times reciprocal of 3
    logic [20:0] r_q2_5;
    logic [63:0] r_p3;
    logic [5:0]  r_min5;
    logic [5:0]  r_sec5;
    // Stage 6: days, hour
    t_split      r_out6;

    logic [26:0] n_q1;
    logic [5:0]  n_sec;
    logic [20:0] n_q2;
    logic [5:0]  n_min;
    t_day_count  n_days;
    logic [4:0]  n_hour;

    // A stage advances when it is empty or its successor advances
    always_comb begin
        stage_en[STAGES] = !r_vld[STAGES] || i_ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    // Valid bit offered to each stage by the one in front of it
    assign vld_in = {r_vld[STAGES-1:1], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    always_comb begin
        n_q1   = r_p1[SHIFT_60 +: 27];
        n_sec  = 6'(r_t1 - 32'(n_q1) * 32'd60);
        n_q2   = r_p2[SHIFT_60 +: 21];
        n_min  = 6'(r_q1_3 - 27'(n_q2) * 27'd60);
        n_days = r_p3[SHIFT_3 +: 16];
        n_hour = 5'(r_q2_5 - 21'(n_days) * 21'd24);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_t1 <= i_epoch;
            r_p1 <= 64'(i_epoch) * 64'(RECIP_60);
        end
        if (stage_en[2]) begin
            r_q1_2 <= n_q1;
            r_sec2 <= n_sec;
        end
        if (stage_en[3]) begin
            r_q1_3 <= r_q1_2;
            r_p2   <= 64'(r_q1_2) * 64'(RECIP_60);
            r_sec3 <= r_sec2;
        end
        if (stage_en[4]) begin
            r_q2_4 <= n_q2;
            r_min4 <= n_min;
            r_sec4 <= r_sec3;
        end
        if (stage_en[5]) begin
            r_q2_5 <= r_q2_4;
            r_p3   <= 64'(r_q2_4[20:3]) * 64'(RECIP_3);
            r_min5 <= r_min4;
            r_sec5 <= r_sec4;
        end
        if (stage_en[6]) begin
            r_out6.days       <= n_days;
            r_out6.hms.hour   <= n_hour;
            r_out6.hms.minute <= r_min5;
            r_out6.hms.second <= r_sec5;
        end
    end

    assign o_ready = stage_en[1];
    assign o_valid = r_vld[STAGES];
    assign o_split = r_out6;

endmodule

### design/cvd_date_find.sv
module cvd_date_find (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  cvd_pkg::t_split  i_split,
    output logic             o_valid,
    input  logic             i_ready,
    output cvd_pkg::t_civil  o_civil
);
    import cvd_pkg::*;

    localparam int unsigned STAGES = 5;

    logic [STAGES:1] r_vld;
    logic [STAGES:1] vld_in;
    logic [STAGES:1] stage_en;

    // Stage 1: day count times reciprocal of a mean year
    t_day_count   r_days1;
    logic [31:0]  r_p1;
    t_hms         r_hms1;
    // Stage 2: year starts around the estimate
    t_day_count   r_days2;
    t_year_idx    r_est2;
    t_day_count   r_lo2;
    t_day_count   r_mid2;
    t_day_count   r_hi2;
    logic [2:0]   r_leap2;
    t_hms         r_hms2;
    // Stage 3: year and day of year
    t_year_idx    r_yidx3;
    t_day_of_year r_doy3;
    logic         r_leap3;
    t_hms         r_hms3;
    // Stage 4: month
    logic [11:0]  r_year4;
    t_month_idx   r_mon4;
    t_day_of_year r_doy4;
    logic         r_leap4;
    t_hms         r_hms4;
    // Stage 5: result
    t_civil       r_out5;

    t_year_idx    est;
    t_year_idx    est_dn;
    t_year_idx    est_up;
    t_year_idx    n_yidx;
    t_day_of_year n_doy;
    logic         n_leap;
    t_month_idx   n_mon;
    t_day_of_year n_mday;

    always_comb begin
        stage_en[STAGES] = !r_vld[STAGES] || i_ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    // Valid bit offered to each stage by the one in front of it
    assign vld_in = {r_vld[STAGES-1:1], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    always_comb begin
        est    = r_p1[SHIFT_YEAR +: 8];
        est_dn = est - 8'd1;
        est_up = est + 8'd1;
    end

    // The true year lies within one of the estimate; take the highest start not past the day
    always_comb begin
        priority if (r_days2 >= r_hi2) begin
            n_yidx = r_est2 + 8'd1;
            n_doy  = 9'(r_days2 - r_hi2);
            n_leap = r_leap2[2];
        end else if (r_days2 >= r_mid2) begin
            n_yidx = r_est2;
            n_doy  = 9'(r_days2 - r_mid2);
            n_leap = r_leap2[1];
        end else begin
            n_yidx = r_est2 - 8'd1;
            n_doy  = 9'(r_days2 - r_lo2);
            n_leap = r_leap2[0];
        end
    end

    // Count the month starts already reached
    always_comb begin
        n_mon = '0;
        for (int k = 1; k < MONTHS; k++) begin
            if (r_doy3 >= month_start(t_month_idx'(k), r_leap3)) begin
                n_mon = n_mon + 4'd1;
            end
        end
    end

    assign n_mday = r_doy4 - month_start(r_mon4, r_leap4) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_days1 <= i_split.days;
            r_p1    <= 32'(i_split.days) * 32'(RECIP_YEAR);
            r_hms1  <= i_split.hms;
        end
        if (stage_en[2]) begin
            r_days2 <= r_days1;
            r_est2  <= est;
            r_lo2   <= YEAR_START[est_dn];
            r_mid2  <= YEAR_START[est];
            r_hi2   <= YEAR_START[est_up];
            r_leap2 <= {LEAP_TAB[est_up], LEAP_TAB[est], LEAP_TAB[est_dn]};
            r_hms2  <= r_hms1;
        end
        if (stage_en[3]) begin
            r_yidx3 <= n_yidx;
            r_doy3  <= n_doy;
            r_leap3 <= n_leap;
            r_hms3  <= r_hms2;
        end
        if (stage_en[4]) begin
            r_year4 <= 12'(BASE_YEAR) + 12'(r_yidx3);
            r_mon4  <= n_mon;
            r_doy4  <= r_doy3;
            r_leap4 <= r_leap3;
            r_hms4  <= r_hms3;
        end
        if (stage_en[5]) begin
            r_out5.year  <= r_year4;
            r_out5.month <= r_mon4 + 4'd1;
            r_out5.day   <= n_mday[4:0];
            r_out5.hms   <= r_hms4;
        end
    end

    assign o_ready = stage_en[1];
    assign o_valid = r_vld[STAGES];
    assign o_civil = r_out5;

endmodule

### design/epoch_seconds_to_civil_date_unit.sv
// Throughput: one request per cycle while the output is not stalled; eleven register
// stages, each with its own valid bit. A stage moves whenever it is empty or the stage
// after it moves, so bubbles close up and a stalled output holds every stage behind it
// without loss. Reset (synchronous, active low) clears only the valid bits, not the data.
module epoch_seconds_to_civil_date_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cvd_req_if.sink          i_req,
    cvd_res_if.source        o_res
);
    import cvd_pkg::*;

    // Hand-off between the time-of-day split and the calendar search
    logic   split_valid;
    logic   split_ready;
    t_split split_data;
    logic   civil_valid;
    t_civil civil_data;

    // Stages 1-6: divide the seconds by 60, 60 and 24 with reciprocal multiplies,
    // each product registered before its quotient is sliced out and the remainder
    // recovered by a constant multiply and subtract.
    cvd_time_split u_time_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_epoch (i_req.epoch_seconds),
        .o_valid (split_valid),
        .i_ready (split_ready),
        .o_split (split_data)
    );

    // Stages 7-11: estimate the year from the day count, settle it against the constant
    // table of year starts, then find the month by comparing the day of year with the
    // eleven month starts after January (shifted one day from March in leap years).
    cvd_date_find u_date_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .o_ready (split_ready),
        .i_split (split_data),
        .o_valid (civil_valid),
        .i_ready (o_res.ready),
        .o_civil (civil_data)
    );

    // The last stage is the output register
    assign o_res.valid      = civil_valid;
    assign o_res.year_out   = civil_data.year;
    assign o_res.month_out  = civil_data.month;
    assign o_res.day_out    = civil_data.day;
    assign o_res.hour_out   = civil_data.hms.hour;
    assign o_res.minute_out = civil_data.hms.minute;
    assign o_res.second_out = civil_data.hms.second;

endmodule

### design/cvd_checker.sv
module cvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_year,
    input logic [3:0]  i_month,
    input logic [4:0]  i_day,
    input logic [4:0]  i_hour,
    input logic [5:0]  i_minute,
    input logic [5:0]  i_second
);
    localparam int unsigned DEPTH = 11;

    logic [4:0] r_pending;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    // Track requests in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_fire && !out_fire) begin
            r_pending <= r_pending + 5'd1;
        end else if (out_fire && !in_fire) begin
            r_pending <= r_pending - 5'd1;
        end
    end

    a_no_result_without_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 5'd0) && (r_pending <= 5'(DEPTH)))
        else $error("result without a pending request");

    a_ready_when_output_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output is free");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_year) && $stable(i_month)
            && $stable(i_day) && $stable(i_hour) && $stable(i_minute) && $stable(i_second))
        else $error("stalled result changed");

    a_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_year >= 12'd1970) && (i_year <= 12'd2106)
            && (i_month >= 4'd1) && (i_month <= 4'd12) && (i_day >= 5'd1)
            && (i_hour <= 5'd23) && (i_minute <= 6'd59) && (i_second <= 6'd59))
        else $error("result field out of range");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result present right after reset");

endmodule

bind epoch_seconds_to_civil_date_unit cvd_checker u_cvd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_year      (o_res.year_out),
    .i_month     (o_res.month_out),
    .i_day       (o_res.day_out),
    .i_hour      (o_res.hour_out),
    .i_minute    (o_res.minute_out),
    .i_second    (o_res.second_out)
);

### sim/civil_date_checker.sv
`timescale 1ns / 100ps

module civil_date_checker
    import cvd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cvd_req_if          i_req,
    cvd_res_if          i_res,
    output int unsigned o_mismatches,
    output int unsigned o_outstanding
);

    localparam int unsigned FEB_IDX      = 1;
    localparam int unsigned LEAP_FEB_LEN = 29;
    localparam int unsigned COMMON_LEN   = 365;
    localparam int unsigned LEAP_LEN     = 366;
    localparam int unsigned REPORT_LIMIT = 10;

    t_civil      expected_dates[$];
    int unsigned mismatch_count = 0;

    function automatic bit gregorian_leap(int unsigned yr);
        return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    endfunction

    function automatic t_civil civil_from_epoch(logic [31:0] secs);
        t_civil      date;
        int unsigned rest;
        int unsigned days;
        int unsigned yr;
        int unsigned ylen;
        int unsigned mon;
        int unsigned mlen;
        bit          leap;
        date.hms.second = 6'(secs % 60);
        rest            = secs / 60;
        date.hms.minute = 6'(rest % 60);
        rest            = rest / 60;
        date.hms.hour   = 5'(rest % 24);
        days            = rest / 24;
        // peel off whole years
        yr   = BASE_YEAR;
        ylen = gregorian_leap(yr) ? LEAP_LEN : COMMON_LEN;
        while (days >= ylen) begin
            days = days - ylen;
            yr   = yr + 1;
            ylen = gregorian_leap(yr) ? LEAP_LEN : COMMON_LEN;
        end
        leap = (ylen == LEAP_LEN);
        // then whole months, never past December
        mon  = 0;
        mlen = MONTH_LEN[0];
        while (mon < MONTHS - 1 && days >= mlen) begin
            days = days - mlen;
            mon  = mon + 1;
            mlen = (mon == FEB_IDX && leap) ? LEAP_FEB_LEN : MONTH_LEN[mon];
        end
        date.year  = 12'(yr);
        date.month = 4'(mon + 1);
        date.day   = 5'(days + 1);
        return date;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_civil got;
        t_civil want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                expected_dates.push_back(civil_from_epoch(i_req.epoch_seconds));
            end
            if (i_res.valid && i_res.ready) begin
                got.year       = i_res.year_out;
                got.month      = i_res.month_out;
                got.day        = i_res.day_out;
                got.hms.hour   = i_res.hour_out;
                got.hms.minute = i_res.minute_out;
                got.hms.second = i_res.second_out;
                if (expected_dates.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("%0t: unexpected date %0d-%0d-%0d %0d:%0d:%0d, no request open",
                                 $realtime, got.year, got.month, got.day,
                                 got.hms.hour, got.hms.minute, got.hms.second);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_dates.pop_front();
                    if (got.year !== want.year || got.month !== want.month ||
                        got.day !== want.day || got.hms.hour !== want.hms.hour ||
                        got.hms.minute !== want.hms.minute ||
                        got.hms.second !== want.hms.second) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("%0t: date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                                     $realtime, want.year, want.month, want.day,
                                     want.hms.hour, want.hms.minute, want.hms.second,
                                     got.year, got.month, got.day,
                                     got.hms.hour, got.hms.minute, got.hms.second);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        o_outstanding <= expected_dates.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

### sim/tb_epoch_seconds_to_civil_date_unit.sv
`timescale 1ns / 100ps

module tb_epoch_seconds_to_civil_date_unit;
    import cvd_pkg::*;

    localparam int unsigned    STALL_LIMIT  = 1000;  // cycles with no handshake at all
    localparam int unsigned    TAIL_CYCLES  = 40;    // well past the pipeline depth
    localparam int unsigned    PHASE_ITEMS  = 450;
    localparam longint unsigned SECS_PER_DAY = 86400;
    localparam int unsigned    LAST_DAY     = 49710; // last day a 32-bit count reaches
    localparam longint unsigned MAX_EPOCH    = 64'hFFFF_FFFF;

    // Calendar landmarks: minute/hour/day rollovers, month and year ends, leap
    // days in an ordinary leap year and in a 400-year century, the skipped leap
    // day of a 100-year century, the signed 32-bit rollover and the largest count.
    localparam logic [31:0] LANDMARKS [24] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd2678399,    32'd2678400,    32'd31535999,   32'd31536000,
        32'd68169600,   32'd94694399,   32'd94694400,   32'd951782400,
        32'd951868800,  32'd2147483647, 32'd2147483648, 32'd4102444799,
        32'd4107542399, 32'd4107542400, 32'd4291747200, 32'd4294967295
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 63;
    int unsigned stall_cycles  = 0;
    int unsigned mismatches;
    int unsigned outstanding;

    cvd_req_if req_ch ();
    cvd_res_if res_ch ();

    epoch_seconds_to_civil_date_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    civil_date_checker date_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #6 i_clk = ~i_clk;

    // Throttle the result side: drop ready in recv_idle_pct percent of cycles.
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort if the channels go quiet for too long; a lost result lands here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("epoch_seconds_to_civil_date_unit regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one request and hold it until the block takes it. Idle cycles go
    // in front, so the caller may change valid once in the step of acceptance.
    task automatic send_request(input logic [31:0] secs);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.epoch_seconds <= secs;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // Run one block of random requests under the given idling mix, then hold
    // the sender until every date already requested has come back.
    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned count);
        longint unsigned secs;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            case ($urandom_range(3))
                0: begin
                    // land on the first or last second of a random day, so
                    // month and year rollovers come up often
                    secs = longint'($urandom_range(LAST_DAY)) * SECS_PER_DAY
                         + ($urandom_range(1) ? SECS_PER_DAY - 1 : 0);
                end
                1: begin
                    // crowd the top of the range, the last years up to 2106
                    secs = MAX_EPOCH - $urandom_range(50_000_000);
                end
                default: begin
                    secs = $urandom();
                end
            endcase
            if (secs > MAX_EPOCH) begin
                secs = MAX_EPOCH;
            end
            send_request(32'(secs));
        end
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        // Drive the request side known before the first edge and hold reset.
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.epoch_seconds <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed landmarks first, under the first idling mix.
        foreach (LANDMARKS[k]) begin
            send_request(LANDMARKS[k]);
        end

        // Sender light, receiver heavy; then swap; then run flat out.
        run_phase(34, 63, PHASE_ITEMS);
        run_phase(63, 34, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);

        // Let any stray result surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("epoch_seconds_to_civil_date_unit regression: pass");
        end else begin
            $display("epoch_seconds_to_civil_date_unit regression: fail");
        end
        $finish;
    end

endmodule

### epoch_seconds_to_civil_date_unit.f
design/cvd_pkg.sv
design/cvd_ifs.sv
design/cvd_time_split.sv
design/cvd_date_find.sv
design/epoch_seconds_to_civil_date_unit.sv
design/cvd_checker.sv
sim/civil_date_checker.sv
sim/tb_epoch_seconds_to_civil_date_unit.sv
